[hw/rtl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg: scanline pixel compositor package
// Command and pixel types, the line register map and the hue/luma palette.
// ----------------------------------------------------------------------------
package spc_pkg;

    typedef enum logic [0:0] {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    // One command transfer
    typedef struct packed {
        cmd_t       command;
        logic [4:0] reg_index;
        logic [7:0] reg_value;
        logic [7:0] pixel_x;
    } cmd_item_t;

    // One pixel transfer
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] column_out;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam int unsigned NUM_REGS = 22;

    // Line register map
    localparam logic [4:0] REG_COLUP0 = 5'd0;
    localparam logic [4:0] REG_COLUP1 = 5'd1;
    localparam logic [4:0] REG_COLUPF = 5'd2;
    localparam logic [4:0] REG_COLUBK = 5'd3;
    localparam logic [4:0] REG_CTRLPF = 5'd4;
    localparam logic [4:0] REG_PF0    = 5'd5;
    localparam logic [4:0] REG_PF1    = 5'd6;
    localparam logic [4:0] REG_PF2    = 5'd7;
    localparam logic [4:0] REG_GRP0   = 5'd8;
    localparam logic [4:0] REG_GRP1   = 5'd9;
    localparam logic [4:0] REG_REFP0  = 5'd10;
    localparam logic [4:0] REG_REFP1  = 5'd11;
    localparam logic [4:0] REG_NUSIZ0 = 5'd12;
    localparam logic [4:0] REG_NUSIZ1 = 5'd13;
    localparam logic [4:0] REG_X0     = 5'd14;
    localparam logic [4:0] REG_X1     = 5'd15;
    localparam logic [4:0] REG_M0_GRP = 5'd16;
    localparam logic [4:0] REG_M1_GRP = 5'd17;
    localparam logic [4:0] REG_BL_GRP = 5'd18;
    localparam logic [4:0] REG_M0_X   = 5'd19;
    localparam logic [4:0] REG_M1_X   = 5'd20;
    localparam logic [4:0] REG_BL_X   = 5'd21;

    // Playfield geometry
    localparam logic [7:0] PF_HALF    = 8'd80;
    localparam logic [4:0] PF_LAST    = 5'd19;

    // Luma ramp: v = LUMA_BASE + LUMA_STEP * luma
    localparam int unsigned LUMA_BASE = 32;
    localparam int unsigned LUMA_STEP = 28;

    // Map a colour byte through the palette (hue in bits 7:4, luma in bits 3:1)
    function automatic rgb_t palette(input logic [7:0] c);
        logic [3:0] hue;
        logic [2:0] luma;
        logic [7:0] v;
        logic [9:0] v3;
        logic [7:0] vq;
        logic [7:0] vh;
        logic [7:0] ve;
        logic [7:0] v34;
        rgb_t       o;
        hue  = c[7:4];
        luma = c[3:1];
        v    = 8'(LUMA_BASE) + 8'({5'd0, luma} * 8'(LUMA_STEP));
        v3   = {2'b00, v} + {1'b0, v, 1'b0};
        vq   = {2'b00, v[7:2]};
        vh   = {1'b0, v[7:1]};
        ve   = {3'b000, v[7:3]};
        v34  = v3[9:2];
        case (hue)
            4'd0:    o = '{r: v,    g: vq,   b: 8'd0};
            4'd1:    o = '{r: v,    g: vh,   b: 8'd0};
            4'd2:    o = '{r: v,    g: v,    b: 8'd0};
            4'd3:    o = '{r: v34,  g: v,    b: 8'd0};
            4'd4:    o = '{r: 8'd0, g: v,    b: 8'd0};
            4'd5:    o = '{r: 8'd0, g: v,    b: vh};
            4'd6:    o = '{r: 8'd0, g: v,    b: v};
            4'd7:    o = '{r: 8'd0, g: v34,  b: v};
            4'd8:    o = '{r: 8'd0, g: 8'd0, b: v};
            4'd9:    o = '{r: vh,   g: 8'd0, b: v};
            4'd10:   o = '{r: v,    g: 8'd0, b: v};
            4'd11:   o = '{r: v,    g: 8'd0, b: v34};
            4'd12:   o = '{r: v,    g: 8'd0, b: 8'd0};
            4'd13:   o = '{r: v,    g: vq,   b: ve};
            4'd14:   o = '{r: v34,  g: ve,   b: 8'd0};
            default: o = '{r: vh,   g: vq,   b: 8'd0};
        endcase
        return o;
    endfunction

endpackage

[hw/rtl/scanline_pixel_compositor.sv]
// ----------------------------------------------------------------------------
// scanline_pixel_compositor
// Line register file and per-pixel object priority with palette lookup.
// ----------------------------------------------------------------------------
// A command transfer either writes one of the 22 line registers (colours,
// playfield, players, missiles, ball) or renders one pixel column. The block
// takes one command every clock while cmd_ready is high: a command lands in
// an input register, the compositing logic works on it in the following
// cycle, and a render leaves its RGB pixel in a result register, which
// offers it on pix until it is taken. Writes leave no pixel. Writes and
// renders pass the input register in order, so a render always sees every
// write sent before it.
// cmd_ready only drops while the input register holds a render and the
// result register is full and not being taken.
module scanline_pixel_compositor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  spc_pkg::cmd_item_t cmd,
    output logic               pix_valid,
    input  logic               pix_ready,
    output spc_pkg::pix_item_t pix
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    spc_pkg::cmd_item_t s1_reg;
    logic               s1_render;
    logic               s1_advance;

    // Result register
    logic               out_valid_reg;
    spc_pkg::pix_item_t out_reg;
    logic               out_free;

    // Line registers
    logic [7:0] line_reg [spc_pkg::NUM_REGS];

    assign s1_render  = (s1_reg.command == spc_pkg::CMD_RENDER);
    assign out_free   = !out_valid_reg || pix_ready;
    // A write always leaves; a render leaves only into a free result slot
    assign s1_advance = s1_valid_reg && (!s1_render || out_free);
    assign cmd_ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
        begin
            s1_reg <= cmd;
        end
    end

    // ------------------------------------------------------------------
    // Line register file: apply a write as it leaves the input register;
    // drop writes to indexes beyond the map
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < spc_pkg::NUM_REGS; i++)
            begin
                line_reg[i] <= 8'd0;
            end
        end
        else if (s1_advance && !s1_render &&
                 (32'(s1_reg.reg_index) < spc_pkg::NUM_REGS))
        begin
            line_reg[s1_reg.reg_index] <= s1_reg.reg_value;
        end
    end

    // ------------------------------------------------------------------
    // Compositing
    // ------------------------------------------------------------------
    logic [7:0]  x;
    logic [7:0]  ctrl;
    logic        prio;
    logic [7:0]  x_mod;
    logic [4:0]  pf_idx;
    logic [19:0] pf_vec;
    logic        pf_hit;

    assign x    = s1_reg.pixel_x;
    assign ctrl = line_reg[spc_pkg::REG_CTRLPF];
    assign prio = ctrl[2];

    // Column modulo 80; x is at most 255, so at most three steps of 80
    always_comb
    begin
        if (x >= 8'(3 * spc_pkg::PF_HALF))
        begin
            x_mod = x - 8'(3 * spc_pkg::PF_HALF);
        end
        else if (x >= 8'(2 * spc_pkg::PF_HALF))
        begin
            x_mod = x - 8'(2 * spc_pkg::PF_HALF);
        end
        else if (x >= spc_pkg::PF_HALF)
        begin
            x_mod = x - spc_pkg::PF_HALF;
        end
        else
        begin
            x_mod = x;
        end
    end

    // Lay the playfield out in display order: pf0 4..7, pf1 7..0, pf2 0..7
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pf_vec[i] = line_reg[spc_pkg::REG_PF0][4 + i];
        end
        for (int i = 0; i < 8; i++)
        begin
            pf_vec[4 + i]  = line_reg[spc_pkg::REG_PF1][7 - i];
            pf_vec[12 + i] = line_reg[spc_pkg::REG_PF2][i];
        end
    end

    // Right half mirrors when reflect is set
    always_comb
    begin
        pf_idx = x_mod[6:2];
        if ((x >= spc_pkg::PF_HALF) && ctrl[0])
        begin
            pf_idx = spc_pkg::PF_LAST - x_mod[6:2];
        end
    end

    assign pf_hit = pf_vec[pf_idx];

    // Ball and missiles: cover pos .. pos + 2^size - 1, no wrap
    logic [7:0] bl_dx;
    logic [7:0] m0_dx;
    logic [7:0] m1_dx;
    logic [7:0] p0_dx;
    logic [7:0] p1_dx;
    logic       bl_hit;
    logic       m0_hit;
    logic       m1_hit;
    logic       p0_hit;
    logic       p1_hit;

    assign bl_dx = x - line_reg[spc_pkg::REG_BL_X];
    assign m0_dx = x - line_reg[spc_pkg::REG_M0_X];
    assign m1_dx = x - line_reg[spc_pkg::REG_M1_X];
    assign p0_dx = x - line_reg[spc_pkg::REG_X0];
    assign p1_dx = x - line_reg[spc_pkg::REG_X1];

    assign bl_hit = (line_reg[spc_pkg::REG_BL_GRP] != 8'd0)
                 && (x >= line_reg[spc_pkg::REG_BL_X])
                 && (bl_dx < (8'd1 << ctrl[5:4]));
    assign m1_hit = (line_reg[spc_pkg::REG_M1_GRP] != 8'd0)
                 && (x >= line_reg[spc_pkg::REG_M1_X])
                 && (m1_dx < (8'd1 << line_reg[spc_pkg::REG_NUSIZ1][5:4]));
    assign m0_hit = (line_reg[spc_pkg::REG_M0_GRP] != 8'd0)
                 && (x >= line_reg[spc_pkg::REG_M0_X])
                 && (m0_dx < (8'd1 << line_reg[spc_pkg::REG_NUSIZ0][5:4]));

    // Players: eight columns, leftmost shows bit 7 (bit 0 when reflected)
    assign p0_hit = (x >= line_reg[spc_pkg::REG_X0]) && (p0_dx < 8'd8)
                 && (line_reg[spc_pkg::REG_REFP0][3]
                     ? line_reg[spc_pkg::REG_GRP0][p0_dx[2:0]]
                     : line_reg[spc_pkg::REG_GRP0][3'd7 - p0_dx[2:0]]);
    assign p1_hit = (x >= line_reg[spc_pkg::REG_X1]) && (p1_dx < 8'd8)
                 && (line_reg[spc_pkg::REG_REFP1][3]
                     ? line_reg[spc_pkg::REG_GRP1][p1_dx[2:0]]
                     : line_reg[spc_pkg::REG_GRP1][3'd7 - p1_dx[2:0]]);

    // Priority select of the winning colour
    logic [7:0]    color;
    spc_pkg::rgb_t rgb;

    always_comb
    begin
        if (prio && pf_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUPF];
        end
        else if (bl_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUPF];
        end
        else if (m1_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUP1];
        end
        else if (m0_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUP0];
        end
        else if (p0_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUP0];
        end
        else if (p1_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUP1];
        end
        else if (pf_hit)
        begin
            color = line_reg[spc_pkg::REG_COLUPF];
        end
        else
        begin
            color = line_reg[spc_pkg::REG_COLUBK];
        end
    end

    assign rgb = spc_pkg::palette(color);

    // ------------------------------------------------------------------
    // Result register: hold until transferred, load a fresh render
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = s1_advance && s1_render;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= '{red: rgb.r, green: rgb.g, blue: rgb.b, column_out: x};
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_render_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("render left the input stage without a result");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !s1_render && out_free) |=> !out_valid_reg)
        else $error("register write produced a pixel");

    a_column_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_reg.column_out == $past(s1_reg.pixel_x)))
        else $error("pixel column does not match its render command");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !s1_render && (s1_reg.reg_index < 5'(spc_pkg::NUM_REGS)))
        |=> (line_reg[$past(s1_reg.reg_index)] == $past(s1_reg.reg_value)))
        else $error("line register write lost");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (s1_valid_reg && s1_render && out_valid_reg && !pix_ready))
        else $error("command stalled without a blocked render");

endmodule
